// File: hdl/sync_framed_packet_receiver_top_assert.svh
// ---------------------------------------------------------------------------
// sfpr assertion macros
// property wrappers shared by the receiver checker
// ---------------------------------------------------------------------------
`ifndef SYNC_FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication
`define SFPR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sfpr_pkg.sv
// ---------------------------------------------------------------------------
// sfpr_pkg
// shared types and constants of the sync framed packet receiver
// ---------------------------------------------------------------------------
package sfpr_pkg;

   localparam int GROUP_LEN_DEF    = 9;
   localparam int BUFFER_BYTES_DEF = 2048;

   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 12;
   localparam int CNT_W1  = CNT_W + 1;
   localparam int BIDX_W  = 11;
   localparam int ID_W    = 24;
   localparam int SPOS_W  = 4;
   localparam int HPOS_W  = 3;

   localparam logic [BYTE_W-1:0] SYNC_BASE = 8'd69;
   localparam logic [SPOS_W-1:0] SYNC_LAST = 4'd8;
   localparam logic [HPOS_W-1:0] HDR_ID_LAST = 3'd3;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_DATA  = 2'd1,
      EV_DONE  = 2'd2,
      EV_ERROR = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      ERR_BUFFER_FULL = 3'd0,
      ERR_BEYOND_SIZE = 3'd1,
      ERR_END_LENGTH  = 3'd2,
      ERR_MARKER      = 3'd3,
      ERR_CHECKSUM    = 3'd4
   } err_code_type;

   typedef struct packed {
      err_code_type        error_code;
      logic [ID_W-1:0]     message_id;
      logic [BYTE_W-1:0]   message_type;
      logic [BIDX_W-1:0]   packet_length;
      logic [BIDX_W-1:0]   byte_index;
      logic [BYTE_W-1:0]   data_byte;
   } rsp_data_type;

   typedef struct packed {
      event_kind_type event_kind;
      rsp_data_type   data;
   } rsp_item_type;

   localparam int RSP_DATA_W  = $bits(rsp_data_type);
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = $bits(event_kind_type);

endpackage

// File: hdl/sfpr_in_stage.sv
// ---------------------------------------------------------------------------
// sfpr_in_stage
// input register holding one received byte until the core takes it
// ---------------------------------------------------------------------------
module sfpr_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [sfpr_pkg::BYTE_W-1:0] req_tdata,
   input  logic                       advance,
   output logic                       in_valid,
   output logic [sfpr_pkg::BYTE_W-1:0] in_byte
);
   import sfpr_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

// File: hdl/sfpr_core.sv
// ---------------------------------------------------------------------------
// sfpr_core
// sync hunt, header capture and data group checking, one byte per cycle while fire is set
// ---------------------------------------------------------------------------
module sfpr_core #(
   parameter int GROUP_LEN    = sfpr_pkg::GROUP_LEN_DEF,
   parameter int BUFFER_BYTES = sfpr_pkg::BUFFER_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [sfpr_pkg::BYTE_W-1:0] rx_byte,
   output sfpr_pkg::rsp_item_type      result
);
   import sfpr_pkg::*;

   localparam int GW = $clog2(GROUP_LEN);
   localparam logic [GW-1:0]     GRP_LAST  = GW'(GROUP_LEN - 1);
   localparam logic [CNT_W1-1:0] BUF_LIMIT = CNT_W1'(BUFFER_BYTES);

   typedef enum logic [2:0] {
      PH_WAIT   = 3'b001,
      PH_HEADER = 3'b010,
      PH_DATA   = 3'b100
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [SPOS_W-1:0] sync_pos_ff, sync_pos_in;
   logic [HPOS_W-1:0] hdr_pos_ff, hdr_pos_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  payload_ff, payload_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic              end_ff, end_in;
   logic [GW-1:0]     grp_ff, grp_in;

   logic              sync_hit;
   logic              err;
   err_code_type      code;

   assign sync_hit = (rx_byte == (SYNC_BASE + {4'b0, sync_pos_ff}));

   always_comb begin
      phase_in    = phase_ff;
      sync_pos_in = sync_pos_ff;
      hdr_pos_in  = hdr_pos_ff;
      limit_in    = limit_ff;
      id_in       = id_ff;
      type_in     = type_ff;
      total_in    = total_ff;
      payload_in  = payload_ff;
      sum_in      = sum_ff;
      end_in      = end_ff;
      grp_in      = grp_ff;
      err         = 1'b0;
      code        = ERR_BUFFER_FULL;
      result      = '0;
      result.event_kind = EV_NONE;

      if (sync_hit && (sync_pos_ff == SYNC_LAST)) begin
         sync_pos_in = '0;
         hdr_pos_in  = '0;
         total_in    = '0;
         payload_in  = '0;
         end_in      = 1'b0;
         grp_in      = '0;
         phase_in    = PH_HEADER;
      end else begin
         sync_pos_in = sync_hit ? sync_pos_ff + 1'b1 : '0;
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_pos_ff == '0) begin
                  limit_in   = CNT_W'(rx_byte) * CNT_W'(GROUP_LEN);
                  hdr_pos_in = hdr_pos_ff + 1'b1;
               end else if (hdr_pos_ff <= HDR_ID_LAST) begin
                  id_in      = {id_ff[ID_W-BYTE_W-1:0], rx_byte};
                  hdr_pos_in = hdr_pos_ff + 1'b1;
               end else begin
                  type_in    = rx_byte;
                  total_in   = '0;
                  payload_in = '0;
                  sum_in     = '0;
                  grp_in     = '0;
                  phase_in   = PH_DATA;
               end
            end
            PH_DATA: begin
               if ({1'b0, payload_ff} >= BUF_LIMIT) begin
                  err  = 1'b1;
                  code = ERR_BUFFER_FULL;
               end else if (total_ff >= limit_ff) begin
                  err  = 1'b1;
                  code = ERR_BEYOND_SIZE;
               end else if (grp_ff == GRP_LAST) begin
                  // checksum byte
                  if (rx_byte[6]) begin
                     if (({1'b0, total_ff} + 1'b1) != {1'b0, limit_ff}) begin
                        err  = 1'b1;
                        code = ERR_END_LENGTH;
                     end else begin
                        end_in = 1'b1;
                     end
                  end
                  if (!err) begin
                     if (!rx_byte[7]) begin
                        err  = 1'b1;
                        code = ERR_MARKER;
                     end else if (rx_byte[5:0] != sum_ff[5:0]) begin
                        err  = 1'b1;
                        code = ERR_CHECKSUM;
                     end else begin
                        sum_in = '0;
                     end
                  end
               end else begin
                  sum_in                 = sum_ff + rx_byte;
                  result.event_kind      = EV_DATA;
                  result.data.data_byte  = rx_byte;
                  result.data.byte_index = payload_ff[BIDX_W-1:0];
                  payload_in             = payload_ff + 1'b1;
               end

               if (err) begin
                  result                  = '0;
                  result.event_kind       = EV_ERROR;
                  result.data.message_type = type_ff;
                  result.data.message_id   = id_ff;
                  result.data.error_code   = code;
                  sum_in                  = '0;
                  phase_in                = PH_WAIT;
               end else begin
                  total_in = total_ff + 1'b1;
                  grp_in   = (grp_ff == GRP_LAST) ? '0 : grp_ff + 1'b1;
                  if (end_in) begin
                     result                    = '0;
                     result.event_kind         = EV_DONE;
                     result.data.packet_length = payload_in[BIDX_W-1:0];
                     result.data.message_type  = type_ff;
                     result.data.message_id    = id_ff;
                     phase_in                  = PH_WAIT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         sync_pos_ff <= '0;
         hdr_pos_ff  <= '0;
         limit_ff    <= '0;
         id_ff       <= '0;
         type_ff     <= '0;
         total_ff    <= '0;
         payload_ff  <= '0;
         sum_ff      <= '0;
         end_ff      <= 1'b0;
         grp_ff      <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         sync_pos_ff <= sync_pos_in;
         hdr_pos_ff  <= hdr_pos_in;
         limit_ff    <= limit_in;
         id_ff       <= id_in;
         type_ff     <= type_in;
         total_ff    <= total_in;
         payload_ff  <= payload_in;
         sum_ff      <= sum_in;
         end_ff      <= end_in;
         grp_ff      <= grp_in;
      end
   end

endmodule

// File: hdl/sfpr_out_stage.sv
// ---------------------------------------------------------------------------
// sfpr_out_stage
// result register driving the response stream
// ---------------------------------------------------------------------------
module sfpr_out_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  sfpr_pkg::rsp_item_type           item,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sfpr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [sfpr_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import sfpr_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = item;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(item_ff.data);
   assign rsp_tuser  = item_ff.event_kind;

endmodule

// File: hdl/sync_framed_packet_receiver_top.sv
// ---------------------------------------------------------------------------
// sync_framed_packet_receiver_top
// byte stream receiver for sync framed packets with grouped checksums
// ---------------------------------------------------------------------------
// req channel: one received byte per word on req_tdata[7:0]
// rsp channel: one result word per received byte; rsp_tuser is the event
//   kind (none, data byte, packet complete, packet error), rsp_tdata holds
//   data byte, index, length, type, id and error code
// a packet starts after the sync run 69..77, then five header bytes, then
//   groups of payload bytes closed by a checksum byte
// path: a taken byte waits in the input register, and its result then in the
//   result register until the receiver takes it
// throughput: one byte per cycle unless rsp stalls, set by the single pass
//   from input register to result register, all state updated in that cycle
// reset: synchronous, clears both stage valids and returns to sync hunt
// rsp stall: the result register holds, the input register keeps or takes
//   one byte, then req_tready stays low until the receiver takes the result
// ---------------------------------------------------------------------------
module sync_framed_packet_receiver_top #(
   parameter int GROUP_LEN    = sfpr_pkg::GROUP_LEN_DEF,
   parameter int BUFFER_BYTES = sfpr_pkg::BUFFER_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rx_byte
   input  logic [sfpr_pkg::BYTE_W-1:0]      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // data_byte, byte_index, packet_length, message_type, message_id,
   // error_code, zero fill
   output logic [sfpr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // event_kind
   output logic [sfpr_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import sfpr_pkg::*;

   logic              in_valid;
   logic [BYTE_W-1:0] in_byte;
   logic              advance;
   rsp_item_type      item;

   assign advance = in_valid && (!rsp_tvalid || rsp_tready);

   sfpr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .in_valid   (in_valid),
      .in_byte    (in_byte)
   );

   sfpr_core #(
      .GROUP_LEN    (GROUP_LEN),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .rx_byte (in_byte),
      .result  (item)
   );

   sfpr_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hdl/sfpr_checker.sv
// ---------------------------------------------------------------------------
// sfpr_checker
// port level checks of the receiver result stream
// ---------------------------------------------------------------------------
`include "sync_framed_packet_receiver_top_assert.svh"

module sfpr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sfpr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [sfpr_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import sfpr_pkg::*;

   rsp_data_type d;
   logic         is_err;
   logic         is_data;

   assign d       = rsp_data_type'(rsp_tdata[RSP_DATA_W-1:0]);
   assign is_err  = rsp_tvalid && (rsp_tuser == EV_ERROR);
   assign is_data = rsp_tvalid && (rsp_tuser == EV_DATA);

   `SFPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed while stalled")
   `SFPR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "rsp valid right after reset")
   `SFPR_ASSERT_NOW(a_code_range, clock, reset, is_err, d.error_code == ERR_BUFFER_FULL || d.error_code == ERR_BEYOND_SIZE || d.error_code == ERR_END_LENGTH || d.error_code == ERR_MARKER || d.error_code == ERR_CHECKSUM, "error code out of range")
   `SFPR_ASSERT_NOW(a_code_only_err, clock, reset, rsp_tvalid && !is_err, d.error_code == ERR_BUFFER_FULL, "error code on a non error word")
   `SFPR_ASSERT_NOW(a_data_clean, clock, reset, is_data, d.packet_length == '0 && d.message_type == '0 && d.message_id == '0, "header fields on a data word")

endmodule

bind sync_framed_packet_receiver_top sfpr_checker u_sfpr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
